### rtl/palette_letterbox_scaler_macros.svh
// Assertion macros for the palette letterbox scaler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PALETTE_LETTERBOX_SCALER_MACROS_SVH
`define PALETTE_LETTERBOX_SCALER_MACROS_SVH
`ifndef SYNTH
`define PLS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PLS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PLS_ASSERT(lbl, cond, msg)
`define PLS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/plbs_pkg.sv
// Shared types and constants for the palette letterbox scaler.
// No dependencies.
package plbs_pkg;

  localparam logic [1:0] KIND_PAL_WR   = 2'd0;
  localparam logic [1:0] KIND_FRAME_WR = 2'd1;
  localparam logic [1:0] KIND_QUERY    = 2'd2;

  localparam logic [2:0] CFG_SRC_W   = 3'd0;
  localparam logic [2:0] CFG_SRC_H   = 3'd1;
  localparam logic [2:0] CFG_PITCH   = 3'd2;
  localparam logic [2:0] CFG_BASE    = 3'd3;
  localparam logic [2:0] CFG_IDX_MSK = 3'd4;

  localparam logic [7:0] FRAME_BYTE_KEEP = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] address;
    logic [15:0] value;
    logic [8:0]  canvas_x;
    logic [7:0]  canvas_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] color;
    logic        inside_res;
  } out_item_t;

  typedef enum logic [2:0] {
    GS_DIV_H,
    GS_DIV_W,
    GS_DIV_X,
    GS_DIV_Y,
    GS_SWEEP,
    GS_READY
  } geom_state_t;

  typedef struct packed {
    logic        in_fit;
    logic [10:0] src;
  } map_ent_t;

  typedef struct packed {
    logic [10:0] index;
    logic        col_we;
    map_ent_t    col;
    logic        row_we;
    map_ent_t    row;
  } map_wr_t;

endpackage

### rtl/palette_letterbox_scaler.sv
// Palette letterbox scaler top level: config registers, pipeline, output skid.
// Accepted requests pass the pipeline stages and output register; throughput
// 1 request/cycle, held by fit setup or a full skid stage (out_ready low for two
// results in a row). Reset (rst_n, synchronous, active low) and every config
// write rerun the fit setup: one to four divisions, then a map fill of
// max(CANVAS_WIDTH, CANVAS_HEIGHT) entries; in_ready stays low.
`include "palette_letterbox_scaler_macros.svh"
module palette_letterbox_scaler #(
  parameter int CANVAS_WIDTH    = 320,
  parameter int CANVAS_HEIGHT   = 240,
  parameter int FRAME_BYTES     = 131072,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  plbs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plbs_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [16:0]          cfg_wdata
);
  import plbs_pkg::*;

  // Configuration registers
  logic [10:0] src_w_r, src_h_r, pitch_r;
  logic [16:0] base_r;
  logic [7:0]  mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 11'd256;
      src_h_r <= 11'd192;
      pitch_r <= 11'd256;
      base_r  <= 17'd0;
      mask_r  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_W:   src_w_r <= cfg_wdata[10:0];
        CFG_SRC_H:   src_h_r <= cfg_wdata[10:0];
        CFG_PITCH:   pitch_r <= cfg_wdata[10:0];
        CFG_BASE:    base_r  <= cfg_wdata;
        CFG_IDX_MSK: mask_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Fit setup: divisions plus map fill
  logic    geom_ready;
  map_wr_t map_wr;

  plbs_geom #(.CW(CANVAS_WIDTH), .CH(CANVAS_HEIGHT)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .src_w   (src_w_r),
    .src_h   (src_h_r),
    .ready   (geom_ready),
    .map_wr  (map_wr)
  );

  // The whole pipeline advances together; only a full skid stage holds it.
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      en, acc, res_valid, push;
  out_item_t res;
  map_ent_t  col_q, row_q;

  assign en       = !skid_valid_r;
  assign in_ready = en && geom_ready;
  assign acc      = in_valid && in_ready;

  plbs_map #(.CW(CANVAS_WIDTH), .CH(CANVAS_HEIGHT)) u_map (
    .clk      (clk),
    .en       (en),
    .map_wr   (map_wr),
    .canvas_x (in_data.canvas_x),
    .canvas_y (in_data.canvas_y),
    .col_q    (col_q),
    .row_q    (row_q)
  );

  plbs_pipe #(
    .CW(CANVAS_WIDTH), .CH(CANVAS_HEIGHT), .FB(FRAME_BYTES), .PE(PALETTE_ENTRIES)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .acc        (acc),
    .in_item    (in_data),
    .col_q      (col_q),
    .row_q      (row_q),
    .row_pitch  (pitch_r),
    .frame_base (base_r),
    .index_mask (mask_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign push = en && res_valid;

  // Output register with one skid entry: drain skid first, park a result
  // in skid when the output is held.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLS_ASSERT(a_skid_needs_out, !skid_valid_r || out_valid_r, "skid full, output empty")
  `PLS_ASSERT_NEXT(a_cfg_reruns_fit, cfg_we, !in_ready, "config write left in_ready high")
  `PLS_ASSERT(a_outside_black, !out_valid_r || out_data_r.inside_res || (out_data_r.color == 16'h0), "outside not black")
endmodule

### rtl/plbs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module plbs_div #(
  parameter int NW = 23,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [NW-1:0]   quo_r;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW:0]     diff;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNTW'(NW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNTW'(1);
      done_r <= (cnt_r == CNTW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

### rtl/plbs_geom.sv
// Fit geometry: divisions for the fitted size and step, then a sweep that
// fills the column and row maps. Depends on plbs_pkg and plbs_div.
module plbs_geom #(
  parameter int CW = 320,
  parameter int CH = 240
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  logic [10:0]         src_w,
  input  logic [10:0]         src_h,
  output logic                ready,
  output plbs_pkg::map_wr_t   map_wr
);
  import plbs_pkg::*;

  localparam int DXW = $clog2(CW + 1);
  localparam int DYW = $clog2(CH + 1);
  localparam int DMW = (DXW > DYW) ? DXW : DYW;
  localparam int NW  = 11 + DMW;
  localparam int DDW = (DMW > 11) ? DMW : 11;
  localparam int SWN = (CW > CH) ? CW : CH;
  localparam int KW  = $clog2(SWN);

  geom_state_t state_r, state_nxt;
  logic          issued_r, issued_nxt;
  logic [DXW-1:0] dw_r, dw_nxt, rx_r, rx_nxt, axr_r, axr_nxt, ox;
  logic [DYW-1:0] dh_r, dh_nxt, ry_r, ry_nxt, ayr_r, ayr_nxt, oy;
  logic [10:0]    qx_r, qx_nxt, qy_r, qy_nxt;
  logic [10:0]    axq_r, axq_nxt, ayq_r, ayq_nxt;
  logic [KW-1:0]  k_r, k_nxt;

  logic [10:0]    sw, sh;
  logic           div_start, div_done;
  logic [NW-1:0]  div_num, div_quo;
  logic [DDW-1:0] div_den, div_rem;
  logic [12:0]    k13;
  logic           live, in_x, in_y;
  logic [DXW:0]   sx_sum;
  logic [DYW:0]   sy_sum;

  assign sw = (src_w == 11'd0) ? 11'd1 : src_w;
  assign sh = (src_h == 11'd0) ? 11'd1 : src_h;

  plbs_div #(.NW(NW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign ox   = DXW'((DXW'(CW) - dw_r) >> 1);
  assign oy   = DYW'((DYW'(CH) - dh_r) >> 1);
  assign k13  = 13'(k_r);
  assign live = (dw_r != '0) && (dh_r != '0);
  assign in_x = live && (k13 >= 13'(ox)) && (k13 < 13'(ox) + 13'(dw_r));
  assign in_y = live && (k13 >= 13'(oy)) && (k13 < 13'(oy) + 13'(dh_r));
  assign sx_sum = {1'b0, axr_r} + {1'b0, rx_r};
  assign sy_sum = {1'b0, ayr_r} + {1'b0, ry_r};

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    dw_nxt = dw_r;  dh_nxt = dh_r;
    qx_nxt = qx_r;  rx_nxt = rx_r;
    qy_nxt = qy_r;  ry_nxt = ry_r;
    axq_nxt = '0;   axr_nxt = '0;
    ayq_nxt = '0;   ayr_nxt = '0;
    k_nxt = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    map_wr    = '0;

    case (state_r)
      GS_DIV_H: begin
        div_num = NW'(sh) * NW'(CW);
        div_den = DDW'(sw);
      end
      GS_DIV_W: begin
        div_num = NW'(sw) * NW'(CH);
        div_den = DDW'(sh);
      end
      GS_DIV_X: begin
        div_num = NW'(sw);
        div_den = DDW'(dw_r);
      end
      GS_DIV_Y: begin
        div_num = NW'(sh);
        div_den = DDW'(dh_r);
      end
      default: begin
      end
    endcase

    case (state_r)
      GS_DIV_H, GS_DIV_W, GS_DIV_X, GS_DIV_Y: begin
        div_start = !issued_r;
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          case (state_r)
            GS_DIV_H: begin
              if (div_quo > NW'(CH)) begin
                dh_nxt    = DYW'(CH);
                state_nxt = GS_DIV_W;
              end else begin
                dh_nxt    = div_quo[DYW-1:0];
                dw_nxt    = DXW'(CW);
                state_nxt = (div_quo == '0) ? GS_SWEEP : GS_DIV_X;
              end
            end
            GS_DIV_W: begin
              dw_nxt    = div_quo[DXW-1:0];
              state_nxt = (div_quo == '0) ? GS_SWEEP : GS_DIV_X;
            end
            GS_DIV_X: begin
              qx_nxt    = div_quo[10:0];
              rx_nxt    = div_rem[DXW-1:0];
              state_nxt = GS_DIV_Y;
            end
            default: begin
              qy_nxt    = div_quo[10:0];
              ry_nxt    = div_rem[DYW-1:0];
              state_nxt = GS_SWEEP;
            end
          endcase
        end
      end
      GS_SWEEP: begin
        map_wr.index      = 11'(k_r);
        map_wr.col_we     = k13 < 13'(CW);
        map_wr.col.in_fit = in_x;
        map_wr.col.src    = axq_r;
        map_wr.row_we     = k13 < 13'(CH);
        map_wr.row.in_fit = in_y;
        map_wr.row.src    = ayq_r;
        // advance the source position only across the fitted image
        axq_nxt = axq_r;  axr_nxt = axr_r;
        ayq_nxt = ayq_r;  ayr_nxt = ayr_r;
        if (in_x) begin
          if (sx_sum >= {1'b0, dw_r}) begin
            axr_nxt = DXW'(sx_sum - {1'b0, dw_r});
            axq_nxt = axq_r + qx_r + 11'd1;
          end else begin
            axr_nxt = sx_sum[DXW-1:0];
            axq_nxt = axq_r + qx_r;
          end
        end
        if (in_y) begin
          if (sy_sum >= {1'b0, dh_r}) begin
            ayr_nxt = DYW'(sy_sum - {1'b0, dh_r});
            ayq_nxt = ayq_r + qy_r + 11'd1;
          end else begin
            ayr_nxt = sy_sum[DYW-1:0];
            ayq_nxt = ayq_r + qy_r;
          end
        end
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(SWN - 1)) state_nxt = GS_READY;
      end
      default: begin
      end
    endcase

    if (restart) begin
      state_nxt  = GS_DIV_H;
      issued_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= GS_DIV_H;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dw_r <= dw_nxt;  dh_r <= dh_nxt;
    qx_r <= qx_nxt;  rx_r <= rx_nxt;
    qy_r <= qy_nxt;  ry_r <= ry_nxt;
    axq_r <= axq_nxt; axr_r <= axr_nxt;
    ayq_r <= ayq_nxt; ayr_r <= ayr_nxt;
    k_r <= k_nxt;
  end

  assign ready = (state_r == GS_READY);
endmodule

### rtl/plbs_map.sv
// Column and row map memories: canvas position to source position.
// Depends on plbs_pkg.
module plbs_map #(
  parameter int CW = 320,
  parameter int CH = 240
) (
  input  logic                clk,
  input  logic                en,
  input  plbs_pkg::map_wr_t   map_wr,
  input  logic [8:0]          canvas_x,
  input  logic [7:0]          canvas_y,
  output plbs_pkg::map_ent_t  col_q,
  output plbs_pkg::map_ent_t  row_q
);
  import plbs_pkg::*;

  localparam int XW = $clog2(CW);
  localparam int YW = $clog2(CH);

  map_ent_t col_mem [CW];
  map_ent_t row_mem [CH];
  map_ent_t col_q_r, row_q_r;
  logic [11:0] cx12, cy12;

  assign cx12 = 12'(canvas_x);
  assign cy12 = 12'(canvas_y);

  always_ff @(posedge clk) begin
    if (map_wr.col_we) col_mem[map_wr.index[XW-1:0]] <= map_wr.col;
    if (en) col_q_r <= col_mem[cx12[XW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_wr.row_we) row_mem[map_wr.index[YW-1:0]] <= map_wr.row;
    if (en) row_q_r <= row_mem[cy12[YW-1:0]];
  end

  assign col_q = col_q_r;
  assign row_q = row_q_r;
endmodule

### rtl/plbs_pipe.sv
// Request pipeline: address multiply, frame store stage, palette stage.
// Depends on plbs_pkg; map read data arrives from plbs_map.
module plbs_pipe #(
  parameter int CW = 320,
  parameter int CH = 240,
  parameter int FB = 131072,
  parameter int PE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                acc,
  input  plbs_pkg::in_item_t  in_item,
  input  plbs_pkg::map_ent_t  col_q,
  input  plbs_pkg::map_ent_t  row_q,
  input  logic [10:0]         row_pitch,
  input  logic [16:0]         frame_base,
  input  logic [7:0]          index_mask,
  output logic                res_valid,
  output plbs_pkg::out_item_t res
);
  import plbs_pkg::*;

  localparam int FW = $clog2(FB);
  localparam int PW = $clog2(PE);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [1:0]  kind1_r, kind2_r, kind3_r, kind4_r;
  logic [16:0] addr1_r, addr2_r, addr3_r;
  logic [15:0] val1_r, val2_r, val3_r;
  logic        inx1_r, iny1_r, in2_r, in3_r, in4_r;
  logic [21:0] prod2_r;
  logic [10:0] sx2_r;
  logic [7:0]  fr3_r;
  logic [15:0] pal4_r;

  logic [7:0]  frame_mem [FB];
  logic [15:0] pal_mem   [PE];

  logic [22:0] fsum;
  logic [20:0] waddr21;
  logic        frame_we, pal_we;
  logic [7:0]  masked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  // stage 1: capture request, map reads land alongside
  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_item.kind;
      addr1_r <= in_item.address;
      val1_r  <= in_item.value;
      inx1_r  <= 12'(in_item.canvas_x) < 12'(CW);
      iny1_r  <= 12'(in_item.canvas_y) < 12'(CH);
    end
  end

  // stage 2: row offset product
  always_ff @(posedge clk) begin
    if (en) begin
      kind2_r <= kind1_r;
      addr2_r <= addr1_r;
      val2_r  <= val1_r;
      in2_r   <= inx1_r && iny1_r && col_q.in_fit && row_q.in_fit;
      prod2_r <= 22'(row_q.src) * 22'(row_pitch);
      sx2_r   <= col_q.src;
    end
  end

  // stage 3: frame store, writes and reads in request order
  assign fsum     = 23'(frame_base) + 23'(prod2_r) + 23'(sx2_r);
  assign waddr21  = 21'(addr2_r);
  assign frame_we = v2_r && (kind2_r == KIND_FRAME_WR) && (waddr21 < 21'(FB));

  always_ff @(posedge clk) begin
    if (en) begin
      if (frame_we) frame_mem[waddr21[FW-1:0]] <= val2_r[7:0] & FRAME_BYTE_KEEP;
      fr3_r   <= frame_mem[fsum[FW-1:0]];
      kind3_r <= kind2_r;
      addr3_r <= addr2_r;
      val3_r  <= val2_r;
      in3_r   <= in2_r;
    end
  end

  // stage 4: palette lookup
  assign masked = fr3_r & index_mask;
  assign pal_we = v3_r && (kind3_r == KIND_PAL_WR) && (addr3_r < 17'(PE));

  always_ff @(posedge clk) begin
    if (en) begin
      if (pal_we) pal_mem[addr3_r[PW-1:0]] <= val3_r;
      pal4_r  <= pal_mem[masked[PW-1:0]];
      kind4_r <= kind3_r;
      in4_r   <= in3_r;
    end
  end

  assign res_valid      = v4_r && (kind4_r == KIND_QUERY);
  assign res.color      = in4_r ? pal4_r : 16'h0;
  assign res.inside_res = in4_r;
endmodule

### dv/palette_letterbox_scaler_checker.sv
// Checker for the palette letterbox scaler: watches the request, result and
// register ports, predicts each query's color and compares. Needs plbs_pkg.
`timescale 1ns / 100ps
module palette_letterbox_scaler_checker #(
  parameter int CANVAS_WIDTH    = 320,
  parameter int CANVAS_HEIGHT   = 240,
  parameter int FRAME_BYTES     = 131072,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  plbs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  plbs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  checked,
  output int                  inside_seen
);
  import plbs_pkg::*;

  logic [10:0] src_w, src_h, pitch;
  logic [16:0] base;
  logic [7:0]  mask;
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [15:0] palette_mem [PALETTE_ENTRIES];
  out_item_t   expected_pixels [$];

  function automatic out_item_t render_pixel(input logic [8:0] cx, input logic [7:0] cy);
    longint unsigned sw, sh, dw, dh, ox, oy, sx, sy, a;
    logic [7:0] ix;
    out_item_t r;
    r  = '0;
    sw = (src_w == 0) ? 1 : src_w;
    sh = (src_h == 0) ? 1 : src_h;
    dw = CANVAS_WIDTH;
    dh = sh * CANVAS_WIDTH / sw;
    if (dh > CANVAS_HEIGHT) begin
      dh = CANVAS_HEIGHT;
      dw = sw * CANVAS_HEIGHT / sh;
    end
    ox = (CANVAS_WIDTH - dw) / 2;
    oy = (CANVAS_HEIGHT - dh) / 2;
    if (dw != 0 && dh != 0 && cx >= ox && cx < ox + dw && cy >= oy && cy < oy + dh) begin
      sy = (cy - oy) * sh / dh;
      sx = (cx - ox) * sw / dw;
      a  = (base + sy * pitch + sx) % FRAME_BYTES;
      ix = frame_mem[a] & mask;
      r.color      = palette_mem[ix % PALETTE_ENTRIES];
      r.inside_res = 1'b1;
    end
    return r;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      src_w <= 11'd256;
      src_h <= 11'd192;
      pitch <= 11'd256;
      base  <= '0;
      mask  <= 8'hFF;
      expected_pixels.delete();
      fail_count  <= 0;
      checked     <= 0;
      inside_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_W:   src_w <= cfg_wdata[10:0];
          CFG_SRC_H:   src_h <= cfg_wdata[10:0];
          CFG_PITCH:   pitch <= cfg_wdata[10:0];
          CFG_BASE:    base  <= cfg_wdata;
          CFG_IDX_MSK: mask  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.kind)
          KIND_PAL_WR:
            if (in_data.address < PALETTE_ENTRIES)
              palette_mem[in_data.address] = in_data.value;
          KIND_FRAME_WR:
            if (in_data.address < FRAME_BYTES)
              frame_mem[in_data.address] = in_data.value[7:0];
          KIND_QUERY:
            expected_pixels.insert(expected_pixels.size(),
                                   render_pixel(in_data.canvas_x, in_data.canvas_y));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result color=%h inside_res=%b", out_data.color,
                 out_data.inside_res);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          checked <= checked + 1;
          if (want.inside_res) inside_seen <= inside_seen + 1;
          if (out_data.color !== want.color) begin
            $error("color: expected %h, actual %h", want.color, out_data.color);
            errs++;
          end
          if (out_data.inside_res !== want.inside_res) begin
            $error("inside_res: expected %b, actual %b", want.inside_res,
                   out_data.inside_res);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

### dv/palette_letterbox_scaler_tb.sv
// Testbench top for the palette letterbox scaler: clock, reset, request and
// register stimulus, result back-pressure and verdict. Needs plbs_pkg and the checker.
`timescale 1ns / 100ps
module palette_letterbox_scaler_tb;
  import plbs_pkg::*;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int FRAME_BYTES = 131072;
  localparam int PHASE_ITEMS = 14;
  localparam int NUM_PHASES  = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;

  int fail_count, pending, checked, inside_seen;

  // Idle percentages, and the long result hold-off handshake with the receiver.
  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // Shadow of the geometry registers, used only to steer stimulus so that
  // no query ever reads a frame byte that was never written.
  int cur_w = 256, cur_h = 192, cur_pitch = 256, cur_base = 0;
  bit byte_written [FRAME_BYTES];

  // Register settings per phase: width, height, pitch, base, mask.
  // Covers a wrapping base, zero fitted height, zero fitted width, zero size
  // treated as one, a 1024 by 1024 source, and a pitch that wraps the store.
  int phase_cfg [NUM_PHASES][5] = '{
    '{8,    6,    8,    131040, 255},
    '{1024, 1,    1024, 0,      15},
    '{1,    1024, 1,    77,     255},
    '{0,    0,    1,    131071, 0},
    '{1024, 1024, 1,    131071, 3},
    '{17,   13,   1024, 130000, 128}
  };

  palette_letterbox_scaler u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  palette_letterbox_scaler_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending, .checked, .inside_seen
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom % 100) >= rx_idle;
    end
  end

  // Locate the frame byte a canvas pixel reads; 0 when outside the fit.
  function automatic bit locate_source(input int cx, input int cy, output int addr);
    int sw, sh, dw, dh, ox, oy;
    sw = (cur_w == 0) ? 1 : cur_w;
    sh = (cur_h == 0) ? 1 : cur_h;
    dw = 320;
    dh = sh * 320 / sw;
    if (dh > 240) begin
      dh = 240;
      dw = sw * 240 / sh;
    end
    ox = (320 - dw) / 2;
    oy = (240 - dh) / 2;
    addr = 0;
    if (dw == 0 || dh == 0 || cx < ox || cx >= ox + dw || cy < oy || cy >= oy + dh)
      return 1'b0;
    addr = (cur_base + ((cy - oy) * sh / dh) * cur_pitch + (cx - ox) * sw / dw)
           % FRAME_BYTES;
    return 1'b1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom});
    return it;
  endfunction

  // Offer one request, idling first at random; hold it until accepted.
  task automatic send(input in_item_t it);
    while (($urandom % 100) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.kind == KIND_FRAME_WR) byte_written[it.address] = 1'b1;
  endtask

  task automatic frame_write(input int addr);
    in_item_t it;
    it = random_item();
    it.kind = KIND_FRAME_WR;
    it.address = 17'(addr);
    send(it);
  endtask

  // Query a pixel, loading its source byte first if it was never written.
  task automatic query_at(input int cx, input int cy);
    in_item_t it;
    int addr;
    if (locate_source(cx, cy, addr) && !byte_written[addr]) frame_write(addr);
    it = random_item();
    it.kind = KIND_QUERY;
    it.canvas_x = 9'(cx);
    it.canvas_y = 8'(cy);
    send(it);
  endtask

  // Drop valid and wait until every expected result is back, then let the
  // pipeline settle so a register write lands on an idle block.
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 17'(val);
    @(posedge clk);
  endtask

  task automatic random_request();
    in_item_t it;
    int r, addr;
    r = $urandom % 100;
    it = random_item();
    if (r < 5) begin
      it.kind = KIND_RESERVED;
      send(it);
    end else if (r < 10) begin
      it.kind = KIND_PAL_WR;
      it.address = 17'($urandom_range(0, 511));
      send(it);
    end else if (r < 45) begin
      if (!locate_source($urandom_range(0, 319), $urandom_range(0, 239), addr))
        addr = int'(it.address);
      frame_write(addr);
    end else if ($urandom % 100 < 85) begin
      query_at($urandom_range(0, 319), $urandom_range(0, 239));
    end else begin
      query_at($urandom_range(0, 511), $urandom_range(0, 255));
    end
  endtask

  initial begin
    in_item_t it;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load the whole palette; extremes at both ends of the table.
    tx_idle = 32;
    rx_idle = 74;
    for (int i = 0; i < 256; i++) begin
      it = random_item();
      it.kind = KIND_PAL_WR;
      it.address = 17'(i);
      if (i == 0) it.value = 16'h0000;
      if (i == 255) it.value = 16'hFFFF;
      send(it);
    end

    // Directed requests at the reset geometry.
    it = random_item();
    it.kind = KIND_PAL_WR;
    it.address = 17'h1FFFF;   // beyond the table: ignored
    send(it);
    it = random_item();
    it.kind = KIND_RESERVED;  // unused kind: no result
    send(it);
    it = random_item();
    it.kind = KIND_FRAME_WR;
    it.address = 0;
    it.value = 16'hFFFF;
    send(it);
    byte_written[0] = 1'b1;
    query_at(0, 0);
    query_at(319, 239);
    query_at(319, 0);
    query_at(0, 239);
    query_at(320, 0);         // just off the canvas
    query_at(0, 240);
    query_at(511, 255);       // both coordinates at their field maximum
    query_at(160, 120);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      for (int r = 0; r < 5; r++) write_reg(3'(r), phase_cfg[p][r]);
      cfg_we <= 1'b0;
      cur_w     = phase_cfg[p][0];
      cur_h     = phase_cfg[p][1];
      cur_pitch = phase_cfg[p][2];
      cur_base  = phase_cfg[p][3];
      if (p == 2) begin
        tx_idle = 74;
        rx_idle = 32;
      end else if (p == 4) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (p == NUM_PHASES - 1) begin
        // Hold results off for a long stretch while queries keep coming,
        // so the pipeline fills and back-pressures the request side.
        hold_go = ~hold_go;
        for (int q = 0; q < 30; q++) query_at($urandom_range(0, 319), $urandom_range(0, 239));
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_request();
        n++;
      end
      // Pause the sender until every result is in.
      if (p == 1) drain();
    end

    drain();
    $display("Checked %0d query results (%0d inside the fitted image) over %0d geometries.",
             checked, inside_seen, NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/plbs_pkg.sv
rtl/plbs_div.sv
rtl/plbs_geom.sv
rtl/plbs_map.sv
rtl/plbs_pipe.sv
rtl/palette_letterbox_scaler.sv
dv/palette_letterbox_scaler_checker.sv
dv/palette_letterbox_scaler_tb.sv
